>>> src/sdspi_pkg.sv
// Package with phase codes, status codes and shared constants of the SD SPI host sequencer.
`timescale 1ns / 1ps
`default_nettype none
package sdspi_pkg;

  localparam int unsigned BlockBytes = 512;
  localparam int unsigned BcW = 10;

  typedef enum logic [3:0] {
    P_IDLE, P_WARM, P_PRE, P_FRAME, P_POLL, P_R7, P_OCR,
    P_RD_TOKEN, P_RD_DATA, P_RD_CRC,
    P_WR_DATA, P_WR_CRC, P_WR_RESP, P_WR_BUSY, P_WR_TRAIL, P_RELEASE
  } phase_e;

  typedef enum logic [1:0] {OP_INIT, OP_READ, OP_WRITE} op_e;

  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0, CMD_INIT = 2'd1, CMD_READ = 2'd2, CMD_WRITE = 2'd3
  } command_e;

  typedef enum logic [1:0] {
    REG_REPLY = 2'd0, REG_TOKEN = 2'd1, REG_BUSY = 2'd2, REG_RETRY = 2'd3
  } reg_e;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_PARAM = 3'd1;
  localparam logic [2:0] ST_NOT_READY = 3'd2;
  localparam logic [2:0] ST_CARD = 3'd3;
  localparam logic [2:0] ST_INIT_FAIL = 3'd4;

  typedef struct packed {
    logic [7:0]  reply_lim;
    logic [15:0] token_lim;
    logic [23:0] busy_lim;
    logic [19:0] retry_lim;
  } cfg_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       cs_high;
    logic       fast_clock;
    logic       rd_valid;
    logic [7:0] rd_data;
    logic       wants;
    logic       done;
    logic [2:0] status;
    logic       card_ready;
  } result_t;

endpackage
`default_nettype wire

>>> src/sd_card_spi_host_sequencer_top.sv
// Top level of the SD SPI host sequencer: input handshake, core and output register.
// The result of an accepted transaction is on the output register in the next cycle.
// Throughput: one transaction per cycle, set by the output register and next-state logic,
// unless out_ready_i stalls. The result register refills in the same cycle it is drained.
// Reset: asynchronous active low; phase idle, counters cleared, limits at defaults.
`timescale 1ns / 1ps
`default_nettype none
module sd_card_spi_host_sequencer_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [23:0] cfg_wdata_i,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [1:0]  command_i,
  input  wire  [1:0]  drive_i,
  input  wire  [31:0] sector_i,
  input  wire  [7:0]  block_count_i,
  input  wire  [7:0]  rx_byte_i,
  input  wire  [7:0]  wr_data_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        chip_select_high_o,
  output logic        fast_clock_o,
  output logic        rd_valid_o,
  output logic [7:0]  rd_data_o,
  output logic        wants_write_byte_o,
  output logic        done_res_o,
  output logic [2:0]  status_o,
  output logic        card_ready_o
);
  import sdspi_pkg::*;

  cfg_t    cfg;
  result_t res, res_q;
  logic    vld_q, step;

  assign in_ready_o = !vld_q || out_ready_i;
  assign step = in_valid_i && in_ready_o;

  sdspi_cfg u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i, .cfg_o(cfg)
  );

  sdspi_core u_core (
    .clk_i, .rst_ni, .step_i(step), .cfg_i(cfg), .command_i, .drive_i, .sector_i,
    .block_count_i, .rx_byte_i, .wr_data_i, .res_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) res_q <= res;
  end

  assign out_valid_o        = vld_q;
  assign tx_valid_o         = res_q.tx_valid;
  assign tx_byte_o          = res_q.tx_byte;
  assign chip_select_high_o = res_q.cs_high;
  assign fast_clock_o       = res_q.fast_clock;
  assign rd_valid_o         = res_q.rd_valid;
  assign rd_data_o          = res_q.rd_data;
  assign wants_write_byte_o = res_q.wants;
  assign done_res_o         = res_q.done;
  assign status_o           = res_q.status;
  assign card_ready_o       = res_q.card_ready;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && !out_ready_i |=> vld_q && $stable(res_q))
    else $error("result changed while stalled");
  a_cs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && !res_q.tx_valid |-> res_q.cs_high && res_q.tx_byte == 8'd0)
    else $error("idle exchange drives bus");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && res_q.done |-> !res_q.tx_valid && !res_q.rd_valid)
    else $error("done with traffic");
endmodule
`default_nettype wire

>>> src/sdspi_cfg.sv
// Configuration register file of the SD SPI host sequencer.
`timescale 1ns / 1ps
`default_nettype none
module sdspi_cfg (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire  [1:0]          cfg_index_i,
  input  wire  [23:0]         cfg_wdata_i,
  output sdspi_pkg::cfg_t     cfg_o
);
  import sdspi_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reply_lim <= 8'd10;
      cfg_q.token_lim <= 16'd20000;
      cfg_q.busy_lim  <= 24'd1048576;
      cfg_q.retry_lim <= 20'd200000;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_REPLY: cfg_q.reply_lim <= cfg_wdata_i[7:0];
        REG_TOKEN: cfg_q.token_lim <= cfg_wdata_i[15:0];
        REG_BUSY:  cfg_q.busy_lim  <= cfg_wdata_i;
        REG_RETRY: cfg_q.retry_lim <= cfg_wdata_i[19:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;
endmodule
`default_nettype wire

>>> src/sdspi_core.sv
// Sequencer state and per-item next-state logic of the SD SPI host sequencer.
`timescale 1ns / 1ps
`default_nettype none
module sdspi_core (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    step_i,
  input  sdspi_pkg::cfg_t        cfg_i,
  input  wire  [1:0]             command_i,
  input  wire  [1:0]             drive_i,
  input  wire  [31:0]            sector_i,
  input  wire  [7:0]             block_count_i,
  input  wire  [7:0]             rx_byte_i,
  input  wire  [7:0]             wr_data_i,
  output sdspi_pkg::result_t     res_o
);
  import sdspi_pkg::*;

  phase_e      phase_q, phase_d;
  logic [BcW-1:0] bc_q, bc_d;
  logic [24:0] poll_q, poll_d;
  logic [19:0] att_q, att_d;
  logic [31:0] sec_q, sec_d;
  logic [7:0]  left_q, left_d;
  logic [47:0] frame_q, frame_d;
  logic        v2_q, v2_d, init_q, init_d, fast_q, fast_d;
  logic [7:0]  echo_q, echo_d;
  op_e         op_q, op_d;
  logic [2:0]  pend_q, pend_d;
  result_t     r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE; bc_q <= '0; poll_q <= '0; att_q <= '0;
      sec_q <= '0; left_q <= '0; frame_q <= '0; v2_q <= 1'b0;
      init_q <= 1'b0; fast_q <= 1'b0; echo_q <= '0; op_q <= OP_INIT;
      pend_q <= ST_OK;
    end else if (step_i) begin
      phase_q <= phase_d; bc_q <= bc_d; poll_q <= poll_d; att_q <= att_d;
      sec_q <= sec_d; left_q <= left_d; frame_q <= frame_d; v2_q <= v2_d;
      init_q <= init_d; fast_q <= fast_d; echo_q <= echo_d; op_q <= op_d;
      pend_q <= pend_d;
    end
  end

  always_comb begin
    logic [5:0]     cmd, nc;
    logic [31:0]    narg;
    logic           do_start, do_rel, do_fb, do_acmd, do_iok;
    logic [2:0]     rel_st;
    logic [BcW-1:0] bc1;
    logic [24:0]    poll1;
    logic [19:0]    att1;
    logic [7:0]     lim8;
    logic [15:0]    lim16;
    logic [7:0]     crc;
    phase_d = phase_q; bc_d = bc_q; poll_d = poll_q; att_d = att_q;
    sec_d = sec_q; left_d = left_q; frame_d = frame_q; v2_d = v2_q;
    init_d = init_q; fast_d = fast_q; echo_d = echo_q; op_d = op_q;
    pend_d = pend_q;
    r = '0; r.cs_high = 1'b1;
    cmd = frame_q[45:40];
    nc = 6'd0; narg = '0;
    do_start = 1'b0; do_rel = 1'b0; do_fb = 1'b0; do_acmd = 1'b0; do_iok = 1'b0;
    rel_st = ST_OK; crc = 8'h01;
    bc1 = bc_q + 1'b1;
    poll1 = poll_q + 1'b1;
    att1 = att_q + 1'b1;
    lim8 = (cfg_i.reply_lim == 8'd0) ? 8'd1 : cfg_i.reply_lim;
    lim16 = (cfg_i.token_lim == 16'd0) ? 16'd1 : cfg_i.token_lim;

    if (command_e'(command_i) == CMD_BYTE) begin
      unique case (phase_q)
        P_WARM: begin
          bc_d = bc1;
          if (bc1 < BcW'(10)) begin r.tx_valid = 1'b1; r.tx_byte = 8'hFF; end
          else begin do_start = 1'b1; nc = 6'd0; end
        end
        P_PRE: begin
          bc_d = bc1;
          if (bc1 < BcW'(2)) begin r.tx_valid = 1'b1; r.tx_byte = 8'hFF; end
          else begin
            phase_d = P_FRAME; bc_d = '0;
            r.tx_valid = 1'b1; r.tx_byte = frame_q[47:40]; r.cs_high = 1'b0;
          end
        end
        P_FRAME: begin
          bc_d = bc1;
          r.tx_valid = 1'b1; r.cs_high = 1'b0; r.tx_byte = 8'hFF;
          if (bc1 < BcW'(6)) begin
            case (bc1[2:0])
              3'd1: r.tx_byte = frame_q[39:32];
              3'd2: r.tx_byte = frame_q[31:24];
              3'd3: r.tx_byte = frame_q[23:16];
              3'd4: r.tx_byte = frame_q[15:8];
              default: r.tx_byte = frame_q[7:0];
            endcase
          end else begin phase_d = P_POLL; poll_d = '0; end
        end
        P_POLL: begin
          poll_d = poll1;
          if (!rx_byte_i[7] || poll1 >= {17'd0, lim8}) begin
            case (cmd)
              6'd0: if (rx_byte_i != 8'd1) begin do_rel = 1'b1; rel_st = ST_INIT_FAIL; end
                    else begin do_start = 1'b1; nc = 6'd8; narg = 32'h1AA; end
              6'd8: if (rx_byte_i == 8'd1) begin
                      phase_d = P_R7; bc_d = '0;
                      r.tx_valid = 1'b1; r.tx_byte = 8'hFF; r.cs_high = 1'b0;
                    end else do_acmd = 1'b1;
              6'd55: if (rx_byte_i > 8'd1) begin v2_d = 1'b0; do_fb = 1'b1; end
                     else begin
                       do_start = 1'b1; nc = 6'd41; narg = v2_q ? 32'h4000_0000 : 32'd0;
                     end
              6'd41: if (rx_byte_i == 8'd0) begin
                       if (v2_q) begin do_start = 1'b1; nc = 6'd58; end
                       else do_iok = 1'b1;
                     end else begin
                       att_d = att1;
                       if (att1 >= cfg_i.retry_lim) do_fb = 1'b1;
                       else begin do_start = 1'b1; nc = 6'd55; end
                     end
              6'd58: if (rx_byte_i == 8'd0) begin
                       phase_d = P_OCR; bc_d = '0;
                       r.tx_valid = 1'b1; r.tx_byte = 8'hFF; r.cs_high = 1'b0;
                     end else do_iok = 1'b1;
              6'd1: begin
                do_rel = 1'b1;
                if (rx_byte_i == 8'd0) init_d = 1'b1; else rel_st = ST_INIT_FAIL;
              end
              6'd17: if (rx_byte_i != 8'd0) begin do_rel = 1'b1; rel_st = ST_CARD; end
                     else begin
                       phase_d = P_RD_TOKEN; poll_d = '0;
                       r.tx_valid = 1'b1; r.tx_byte = 8'hFF; r.cs_high = 1'b0;
                     end
              6'd24: if (rx_byte_i != 8'd0) begin do_rel = 1'b1; rel_st = ST_CARD; end
                     else begin
                       phase_d = P_WR_DATA; bc_d = '0; r.wants = 1'b1;
                       r.tx_valid = 1'b1; r.tx_byte = 8'hFE; r.cs_high = 1'b0;
                     end
              default: begin do_rel = 1'b1; rel_st = ST_CARD; end
            endcase
          end else begin r.tx_valid = 1'b1; r.tx_byte = 8'hFF; r.cs_high = 1'b0; end
        end
        P_R7: begin
          bc_d = bc1;
          if (bc1 == BcW'(3)) echo_d = rx_byte_i;
          if (bc1 == BcW'(4) && echo_q == 8'h01 && rx_byte_i == 8'hAA) v2_d = 1'b1;
          if (bc1 < BcW'(5)) begin r.tx_valid = 1'b1; r.tx_byte = 8'hFF; r.cs_high = 1'b0; end
          else do_acmd = 1'b1;
        end
        P_OCR: begin
          bc_d = bc1;
          if (bc1 < BcW'(4)) begin r.tx_valid = 1'b1; r.tx_byte = 8'hFF; r.cs_high = 1'b0; end
          else do_iok = 1'b1;
        end
        P_RD_TOKEN: begin
          poll_d = poll1;
          if (rx_byte_i != 8'hFF || poll1 >= {9'd0, lim16}) begin
            if (rx_byte_i == 8'hFE) begin
              phase_d = P_RD_DATA; bc_d = '0;
              r.tx_valid = 1'b1; r.tx_byte = 8'hFF; r.cs_high = 1'b0;
            end else begin do_rel = 1'b1; rel_st = ST_CARD; end
          end else begin r.tx_valid = 1'b1; r.tx_byte = 8'hFF; r.cs_high = 1'b0; end
        end
        P_RD_DATA: begin
          r.rd_valid = 1'b1; r.rd_data = rx_byte_i;
          bc_d = bc1;
          if ({1'b0, bc1} >= (BcW+1)'(BlockBytes)) begin phase_d = P_RD_CRC; bc_d = '0; end
          r.tx_valid = 1'b1; r.tx_byte = 8'hFF; r.cs_high = 1'b0;
        end
        P_RD_CRC: begin
          bc_d = bc1;
          if (bc1 < BcW'(2)) begin r.tx_valid = 1'b1; r.tx_byte = 8'hFF; r.cs_high = 1'b0; end
          else begin
            left_d = left_q - 1'b1; sec_d = sec_q + 1'b1; do_rel = 1'b1;
          end
        end
        P_WR_DATA: begin
          r.tx_valid = 1'b1; r.tx_byte = wr_data_i; r.cs_high = 1'b0;
          bc_d = bc1;
          if ({1'b0, bc1} >= (BcW+1)'(BlockBytes)) begin phase_d = P_WR_CRC; bc_d = '0; end
          else r.wants = 1'b1;
        end
        P_WR_CRC: begin
          bc_d = bc1;
          r.tx_valid = 1'b1; r.tx_byte = 8'hFF; r.cs_high = 1'b0;
          if (bc1 >= BcW'(3)) phase_d = P_WR_RESP;
        end
        P_WR_RESP: begin
          if (rx_byte_i[4:0] != 5'h05) begin do_rel = 1'b1; rel_st = ST_CARD; end
          else begin
            phase_d = P_WR_BUSY; poll_d = '0;
            r.tx_valid = 1'b1; r.tx_byte = 8'hFF; r.cs_high = 1'b0;
          end
        end
        P_WR_BUSY: begin
          if (rx_byte_i == 8'hFF) begin
            phase_d = P_WR_TRAIL;
            r.tx_valid = 1'b1; r.tx_byte = 8'hFF; r.cs_high = 1'b0;
          end else if (poll_q > {1'b0, cfg_i.busy_lim}) begin
            do_rel = 1'b1; rel_st = ST_CARD;
          end else begin
            poll_d = poll1;
            r.tx_valid = 1'b1; r.tx_byte = 8'hFF; r.cs_high = 1'b0;
          end
        end
        P_WR_TRAIL: begin
          left_d = left_q - 1'b1; sec_d = sec_q + 1'b1; do_rel = 1'b1;
        end
        P_RELEASE: begin
          if (pend_q == ST_OK && op_q != OP_INIT && left_q != 8'd0) begin
            do_start = 1'b1; nc = (op_q == OP_READ) ? 6'd17 : 6'd24; narg = sec_q;
          end else begin
            phase_d = P_IDLE; r.done = 1'b1; r.status = pend_q;
          end
        end
        default: phase_d = P_IDLE;
      endcase
    end else if (phase_q == P_IDLE) begin
      if (command_e'(command_i) == CMD_INIT) begin
        if (drive_i != 2'd0) begin r.done = 1'b1; r.status = ST_INIT_FAIL; end
        else begin
          fast_d = 1'b0; init_d = 1'b0; v2_d = 1'b0; op_d = OP_INIT;
          phase_d = P_WARM; bc_d = '0;
          r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
        end
      end else begin
        if (drive_i != 2'd0 || block_count_i == 8'd0) begin
          r.done = 1'b1; r.status = ST_PARAM;
        end else if (!init_q) begin
          r.done = 1'b1; r.status = ST_NOT_READY;
        end else begin
          op_d = (command_e'(command_i) == CMD_READ) ? OP_READ : OP_WRITE;
          sec_d = sector_i; left_d = block_count_i;
          do_start = 1'b1; narg = sector_i;
          nc = (command_e'(command_i) == CMD_READ) ? 6'd17 : 6'd24;
        end
      end
    end

    if (do_acmd) begin
      att_d = '0;
      if (cfg_i.retry_lim == 20'd0) do_fb = 1'b1;
      else begin do_start = 1'b1; nc = 6'd55; narg = '0; end
    end
    if (do_fb) begin
      if (!v2_d) begin do_start = 1'b1; nc = 6'd1; narg = '0; end
      else begin do_rel = 1'b1; rel_st = ST_INIT_FAIL; end
    end
    if (do_iok) begin
      fast_d = 1'b1; init_d = 1'b1; do_rel = 1'b1; rel_st = ST_OK;
    end
    if (do_start) begin
      if (nc == 6'd0) crc = 8'h95;
      else if (nc == 6'd8) crc = 8'h87;
      frame_d = {2'b01, nc, narg, crc};
      phase_d = P_PRE; bc_d = '0;
      r.tx_valid = 1'b1; r.tx_byte = 8'hFF; r.cs_high = 1'b1;
    end
    if (do_rel) begin
      phase_d = P_RELEASE; pend_d = rel_st;
      r.tx_valid = 1'b1; r.tx_byte = 8'hFF; r.cs_high = 1'b1;
    end
    r.fast_clock = fast_d;
    r.card_ready = init_d;
  end

  assign res_o = r;
endmodule
`default_nettype wire
